@@ hw/rtl/mmda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmda_pkg
// Shared types and constants for the double-and-add modular multiplier.
// ----------------------------------------------------------------------------
package mmda_pkg;

    // Width of operands, modulus and result.
    localparam int DATA_W    = 63;
    // Default number of multiplier bits the scan may cover.
    localparam int WIDTH_DEF = 64;
    // Reduction counter: counts operand bits from the top one down to zero.
    localparam int RED_CNT_W = $clog2(DATA_W);
    localparam logic [RED_CNT_W-1:0] RED_FIRST = RED_CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic reduce_step;
        logic scan_step;
        logic store_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_zero;
        logic reduce_last;
        logic scan_done;
    } t_status;

endpackage

@@ hw/rtl/mod_mul_double_and_add.sv @@
`timescale 1ns / 1ps
// Sequence: load, reduction of both operands, then a scan of the multiplier bits
// (up to WIDTH, stopping when the rest is zero), a check and a store.
// One word is in work at a time.
// A zero modulus skips reduction and scan and returns zero.
// The output register holds a finished word while the next one is computed.
// Reset (synchronous, active low) sets the modulus to one and empties the block.
// ----------------------------------------------------------------------------
// mod_mul_double_and_add
// Modular multiplier: (multiplicand * multiplier) mod modulus by double-and-add.
// ----------------------------------------------------------------------------
//
// Both operands are reduced in parallel by restoring shift-and-subtract, one
// bit per cycle, so the length of the reduction is set by the operand width. The
// scan then consumes one multiplier bit per cycle: on a set bit the current
// multiplicand is added to the accumulator, and the multiplicand is doubled.
// Each add or double is followed by one conditional subtraction of m. All
// sums are 64 bits wide, so no modulus below 2^63 can overflow.
//
// The user must write the modulus via i_cfg_we / i_cfg_data only while idle; the block does not enforce it.
module mod_mul_double_and_add import mmda_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_multiplicand,
    input  logic [DATA_W-1:0] i_multiplier,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_product_mod
);

    t_cmd    cmd;
    t_status status;

    mmda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mmda_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_product_mod  (o_product_mod)
    );

endmodule

@@ hw/rtl/mmda_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmda_datapath
// Modulus register, restoring reduction of both operands, double-and-add scan.
// ----------------------------------------------------------------------------
module mmda_datapath import mmda_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic [DATA_W-1:0] i_multiplicand,
    input  logic [DATA_W-1:0] i_multiplier,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [DATA_W-1:0] o_product_mod
);

    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam logic [CNT_W-1:0] SCAN_MAX = CNT_W'(WIDTH);

    // One conditional subtraction of m after a value below 2m was formed.
    function automatic logic [DATA_W-1:0] cond_sub(logic [DATA_W:0] t, logic [DATA_W-1:0] m);
        logic [DATA_W:0] d;
        d = t - {1'b0, m};
        if (t >= {1'b0, m}) begin
            return d[DATA_W-1:0];
        end
        return t[DATA_W-1:0];
    endfunction

    logic [DATA_W-1:0]    r_mod;
    logic [DATA_W-1:0]    r_sa, r_sb;
    logic [DATA_W-1:0]    r_a, r_b, r_acc, r_out;
    logic [RED_CNT_W-1:0] r_red_cnt;
    logic [CNT_W-1:0]     r_scan;

    logic [DATA_W-1:0] n_a_red, n_b_red, n_acc_add, n_a_dbl;

    always_comb begin
        n_a_red   = cond_sub({r_a, r_sa[DATA_W-1]}, r_mod);
        n_b_red   = cond_sub({r_b, r_sb[DATA_W-1]}, r_mod);
        n_acc_add = cond_sub({1'b0, r_acc} + {1'b0, r_a}, r_mod);
        n_a_dbl   = cond_sub({r_a, 1'b0}, r_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= DATA_W'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sa      <= i_multiplicand;
            r_sb      <= i_multiplier;
            r_a       <= '0;
            r_b       <= '0;
            r_acc     <= '0;
            r_red_cnt <= RED_FIRST;
            r_scan    <= '0;
        end else if (i_cmd.reduce_step) begin
            r_sa      <= {r_sa[DATA_W-2:0], 1'b0};
            r_sb      <= {r_sb[DATA_W-2:0], 1'b0};
            r_a       <= n_a_red;
            r_b       <= n_b_red;
            r_red_cnt <= r_red_cnt - RED_CNT_W'(1);
        end else if (i_cmd.scan_step) begin
            if (r_b[0]) begin
                r_acc <= n_acc_add;
            end
            r_a    <= n_a_dbl;
            r_b    <= {1'b0, r_b[DATA_W-1:1]};
            r_scan <= r_scan + CNT_W'(1);
        end
        if (i_cmd.store_out) begin
            r_out <= r_acc;
        end
    end

    always_comb begin
        o_status.mod_zero    = (r_mod == '0);
        o_status.reduce_last = (r_red_cnt == '0);
        o_status.scan_done   = (r_b == '0) || (r_scan == SCAN_MAX);
    end

    assign o_product_mod = r_out;

endmodule

@@ hw/rtl/mmda_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmda_ctrl
// Sequencer for reduction and scan, plus the output word handshake.
// ----------------------------------------------------------------------------
module mmda_ctrl import mmda_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.mod_zero ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                if (i_status.reduce_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DONE: begin
                // The result register frees up when its word is taken.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.store_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/mmda_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmda_checker
// Port-level checks for the modular multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mmda_checker import mmda_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [DATA_W-1:0] i_cfg_data,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] o_product_mod
);

    // Tracks whether the modulus currently equals one.
    logic r_mod_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_one <= 1'b1;
        end else if (i_cfg_we) begin
            r_mod_one <= (i_cfg_data == DATA_W'(1));
        end
    end

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_product_mod))
        else $error("result word changed while stalled");

    // Only one word is in work: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // With modulus one every product is zero.
    a_mod_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mod_one |-> o_product_mod == '0)
        else $error("nonzero result with modulus one");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind mod_mul_double_and_add mmda_checker u_mmda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_data    (i_cfg_data),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_product_mod (o_product_mod)
);
